/* hw/rtl/qmn_pkg.sv */
// Package: widths and item types for the normalized quaternion product.
package qmn_pkg;
  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W = 2 * COMP_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int P_W    = SUM_W - FRAC_BITS;
  localparam int SQ_W   = 2 * P_W;
  localparam int SS_W   = SQ_W + 2;
  localparam int RT_W   = SS_W / 2;
  localparam int REM_W  = RT_W + 2;
  localparam int DR_W   = RT_W + 1;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int NST    = 5 + RT_W + Q_W;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] a_x;
    logic signed [COMP_WIDTH-1:0] a_y;
    logic signed [COMP_WIDTH-1:0] a_z;
    logic signed [COMP_WIDTH-1:0] a_w;
    logic signed [COMP_WIDTH-1:0] b_x;
    logic signed [COMP_WIDTH-1:0] b_y;
    logic signed [COMP_WIDTH-1:0] b_z;
    logic signed [COMP_WIDTH-1:0] b_w;
  } in_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] out_x;
    logic signed [COMP_WIDTH-1:0] out_y;
    logic signed [COMP_WIDTH-1:0] out_z;
    logic signed [COMP_WIDTH-1:0] out_w;
    logic                         zero_norm;
  } out_t;
endpackage

/* hw/rtl/quaternion_multiply_normalize.sv */
// Top level: pipelined Hamilton product, integer square root and normalizing divide.
// Stages: 4 product/norm stages, one square-root stage per root bit,
//   one divide stage per quotient bit, output register.
// Throughput: one item per cycle; every stage advances together when the output
//   register is empty or being taken.
// Reset: synchronous active-low rst_n clears all stage valid bits; data is not reset.
module quaternion_multiply_normalize (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qmn_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qmn_pkg::out_t out_data
);
  import qmn_pkg::*;

  logic             adv;
  logic [NST-1:0]   vld_r;

  logic signed [PROD_W-1:0] prod_r [16];
  logic signed [P_W-1:0]    p_r [4];
  logic [P_W-1:0]           mag3_r [4];
  logic [3:0]               neg3_r;
  logic [SQ_W-1:0]          sq_r [4];
  logic [P_W-1:0]           mag4_r [4];
  logic [3:0]               neg4_r;
  logic [SS_W-1:0]          ss_r;

  logic [REM_W-1:0]         rt_rem_r  [RT_W];
  logic [RT_W-1:0]          rt_root_r [RT_W];
  logic [SS_W-1:0]          rt_rad_r  [RT_W];
  logic [P_W-1:0]           rt_mag_r  [RT_W][4];
  logic [3:0]               rt_neg_r  [RT_W];

  logic [DR_W-1:0]          dv_rem_r [Q_W][4];
  logic [Q_W-1:0]           dv_q_r   [Q_W][4];
  logic [RT_W-1:0]          dv_s_r   [Q_W];
  logic [3:0]               dv_neg_r [Q_W];

  out_t                     out_data_r;

  assign adv       = !vld_r[NST-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // stage: sixteen partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r[0]  <= in_data.a_w * in_data.b_x;
      prod_r[1]  <= in_data.a_x * in_data.b_w;
      prod_r[2]  <= in_data.a_y * in_data.b_z;
      prod_r[3]  <= in_data.a_z * in_data.b_y;
      prod_r[4]  <= in_data.a_w * in_data.b_y;
      prod_r[5]  <= in_data.a_y * in_data.b_w;
      prod_r[6]  <= in_data.a_z * in_data.b_x;
      prod_r[7]  <= in_data.a_x * in_data.b_z;
      prod_r[8]  <= in_data.a_w * in_data.b_z;
      prod_r[9]  <= in_data.a_z * in_data.b_w;
      prod_r[10] <= in_data.a_x * in_data.b_y;
      prod_r[11] <= in_data.a_y * in_data.b_x;
      prod_r[12] <= in_data.a_w * in_data.b_w;
      prod_r[13] <= in_data.a_x * in_data.b_x;
      prod_r[14] <= in_data.a_y * in_data.b_y;
      prod_r[15] <= in_data.a_z * in_data.b_z;
    end
  end

  // stage: sums and rounding to Q.14
  logic signed [SUM_W-1:0] sum_c [4];
  logic signed [SUM_W-1:0] rnd_c [4];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = SUM_W'(prod_r[4*i]) + SUM_W'(prod_r[4*i+1])
               + SUM_W'(prod_r[4*i+2]) - SUM_W'(prod_r[4*i+3]);
    end
    sum_c[3] = SUM_W'(prod_r[12]) - SUM_W'(prod_r[13])
             - SUM_W'(prod_r[14]) - SUM_W'(prod_r[15]);
    for (int i = 0; i < 4; i++) begin
      rnd_c[i] = sum_c[i] + (SUM_W'(1) <<< (FRAC_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= rnd_c[i][SUM_W-1:FRAC_BITS];
      end
    end
  end

  // stage: magnitudes and squares
  logic [P_W-1:0] mag_c [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = p_r[i][P_W-1] ? P_W'(-p_r[i]) : P_W'(p_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        mag3_r[i] <= mag_c[i];
        neg3_r[i] <= p_r[i][P_W-1];
        sq_r[i]   <= SQ_W'(mag_c[i]) * SQ_W'(mag_c[i]);
      end
    end
  end

  // stage: sum of squares
  always_ff @(posedge clk) begin
    if (adv) begin
      ss_r   <= SS_W'(sq_r[0]) + SS_W'(sq_r[1]) + SS_W'(sq_r[2]) + SS_W'(sq_r[3]);
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
    end
  end

  // square root: one root bit per stage
  for (genvar k = 0; k < RT_W; k++) begin : g_rt
    logic [REM_W-1:0]   rem_in;
    logic [RT_W-1:0]    root_in;
    logic [SS_W-1:0]    rad_in;
    logic [P_W-1:0]     mag_in [4];
    logic [3:0]         neg_in;
    logic [REM_W+1:0]   cur;
    logic [REM_W+1:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = ss_r;
      assign mag_in  = mag4_r;
      assign neg_in  = neg4_r;
    end else begin : g_next
      assign rem_in  = rt_rem_r[k-1];
      assign root_in = rt_root_r[k-1];
      assign rad_in  = rt_rad_r[k-1];
      assign mag_in  = rt_mag_r[k-1];
      assign neg_in  = rt_neg_r[k-1];
    end

    assign cur   = {rem_in, rad_in[SS_W-1-2*k -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cur >= trial) begin
          rt_rem_r[k]  <= REM_W'(cur - trial);
          rt_root_r[k] <= {root_in[RT_W-2:0], 1'b1};
        end else begin
          rt_rem_r[k]  <= REM_W'(cur);
          rt_root_r[k] <= {root_in[RT_W-2:0], 1'b0};
        end
        rt_rad_r[k] <= rad_in;
        rt_mag_r[k] <= mag_in;
        rt_neg_r[k] <= neg_in;
      end
    end
  end

  // divide: one quotient bit per stage, four lanes
  for (genvar j = 0; j < Q_W; j++) begin : g_dv
    logic [DR_W-1:0] rem_in [4];
    logic [Q_W-1:0]  q_in   [4];
    logic [RT_W-1:0] s_in;
    logic [3:0]      neg_in;
    logic [DR_W-1:0] t      [4];

    if (j == 0) begin : g_first
      assign s_in   = rt_root_r[RT_W-1];
      assign neg_in = rt_neg_r[RT_W-1];
      for (genvar l = 0; l < 4; l++) begin : g_l
        assign rem_in[l] = DR_W'(rt_mag_r[RT_W-1][l]);
        assign q_in[l]   = '0;
        assign t[l]      = rem_in[l];
      end
    end else begin : g_next
      assign s_in   = dv_s_r[j-1];
      assign neg_in = dv_neg_r[j-1];
      for (genvar l = 0; l < 4; l++) begin : g_l
        assign rem_in[l] = dv_rem_r[j-1][l];
        assign q_in[l]   = dv_q_r[j-1][l];
        assign t[l]      = {rem_in[l][DR_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 4; l++) begin
          if (t[l] >= DR_W'(s_in)) begin
            dv_rem_r[j][l] <= t[l] - DR_W'(s_in);
            dv_q_r[j][l]   <= {q_in[l][Q_W-2:0], 1'b1};
          end else begin
            dv_rem_r[j][l] <= t[l];
            dv_q_r[j][l]   <= {q_in[l][Q_W-2:0], 1'b0};
          end
        end
        dv_s_r[j]   <= s_in;
        dv_neg_r[j] <= neg_in;
      end
    end
  end

  // output register: sign and zero-norm override
  logic [COMP_WIDTH-1:0] res_c [4];
  logic                  zero_c;
  always_comb begin
    zero_c = (dv_s_r[Q_W-1] == '0);
    for (int l = 0; l < 4; l++) begin
      if (zero_c) begin
        res_c[l] = '0;
      end else if (dv_neg_r[Q_W-1][l]) begin
        res_c[l] = COMP_WIDTH'(-COMP_WIDTH'(dv_q_r[Q_W-1][l]));
      end else begin
        res_c[l] = COMP_WIDTH'(dv_q_r[Q_W-1][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_x     <= res_c[0];
      out_data_r.out_y     <= res_c[1];
      out_data_r.out_z     <= res_c[2];
      out_data_r.out_w     <= res_c[3];
      out_data_r.zero_norm <= zero_c;
    end
  end
endmodule
